// ----- design/irec_pkg.sv -----
`timescale 1ns / 1ps

package irec_pkg;

  localparam int REG_COUNT = 32;
  localparam int MEM_WORDS = 4096;
  localparam int RF_AW     = $clog2(REG_COUNT);
  localparam int MEM_AW    = $clog2(MEM_WORDS);

  localparam logic [3:0] OP_NOP   = 4'd0;
  localparam logic [3:0] OP_ADD   = 4'd1;
  localparam logic [3:0] OP_SUB   = 4'd2;
  localparam logic [3:0] OP_MUL   = 4'd3;
  localparam logic [3:0] OP_AND   = 4'd4;
  localparam logic [3:0] OP_OR    = 4'd5;
  localparam logic [3:0] OP_XOR   = 4'd6;
  localparam logic [3:0] OP_MOVC  = 4'd7;
  localparam logic [3:0] OP_LOAD  = 4'd8;
  localparam logic [3:0] OP_STORE = 4'd9;
  localparam logic [3:0] OP_BZ    = 4'd10;
  localparam logic [3:0] OP_BNZ   = 4'd11;
  localparam logic [3:0] OP_JUMP  = 4'd12;
  localparam logic [3:0] OP_HALT  = 4'd13;

  typedef struct packed {
    logic        en;
    logic [4:0]  idx;
    logic [31:0] data;
  } rf_wr_t;

  typedef struct packed {
    logic              wr_en;
    logic              rd_en;
    logic [MEM_AW-1:0] addr;
    logic [31:0]       wdata;
  } dm_req_t;

  typedef struct packed {
    logic [15:0]       next_pc;
    logic              redirect;
    logic              wr;
    logic [4:0]        widx;
    logic [31:0]       res;
    logic              zero;
    logic              halt;
    logic              addr_err;
    logic              is_load;
    logic              is_store;
    logic [MEM_AW-1:0] mem_addr;
  } ex_res_t;

endpackage

// ----- design/irec_regfile.sv -----
`timescale 1ns / 1ps

module irec_regfile (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [4:0]       rd_idx_a,
  input  logic [4:0]       rd_idx_b,
  input  irec_pkg::rf_wr_t wr,
  output logic [31:0]      rd_data_a,
  output logic [31:0]      rd_data_b
);
  import irec_pkg::*;

  logic [31:0]          mem [REG_COUNT];
  logic [REG_COUNT-1:0] vld_r;
  logic [31:0]          data_a_r;
  logic [31:0]          data_b_r;
  logic                 hit_a_r;
  logic                 hit_b_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.idx[RF_AW-1:0]] <= wr.data;
    end
    data_a_r <= mem[rd_idx_a[RF_AW-1:0]];
    data_b_r <= mem[rd_idx_b[RF_AW-1:0]];
  end

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      hit_a_r <= 1'b0;
      hit_b_r <= 1'b0;
    end else begin
      if (wr.en) begin
        vld_r[wr.idx[RF_AW-1:0]] <= 1'b1;
      end
      hit_a_r <= (32'(rd_idx_a) < 32'(REG_COUNT)) && vld_r[rd_idx_a[RF_AW-1:0]];
      hit_b_r <= (32'(rd_idx_b) < 32'(REG_COUNT)) && vld_r[rd_idx_b[RF_AW-1:0]];
    end
  end

  assign rd_data_a = hit_a_r ? data_a_r : '0;
  assign rd_data_b = hit_b_r ? data_b_r : '0;

endmodule

// ----- design/irec_dmem.sv -----
`timescale 1ns / 1ps

module irec_dmem (
  input  logic              clk,
  input  logic              rst_n,
  input  irec_pkg::dm_req_t req,
  output logic [31:0]       rd_data,
  output logic              busy
);
  import irec_pkg::*;

  logic [31:0]       mem [MEM_WORDS];
  logic              clr_r;
  logic [MEM_AW-1:0] clr_addr_r;
  logic [31:0]       rd_data_r;

  // zero sweep after reset, one word per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r      <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_r) begin
      clr_addr_r <= clr_addr_r + MEM_AW'(1);
      if (clr_addr_r == MEM_AW'(MEM_WORDS - 1)) begin
        clr_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clr_r) begin
      mem[clr_addr_r] <= '0;
    end else if (req.wr_en) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.addr];
    end
  end

  assign rd_data = rd_data_r;
  assign busy    = clr_r;

endmodule

// ----- design/irec_alu.sv -----
`timescale 1ns / 1ps

module irec_alu (
  input  logic               [3:0]  op,
  input  logic               [4:0]  dest,
  input  logic signed        [15:0] imm,
  input  logic               [15:0] pc,
  input  logic               [31:0] a,
  input  logic               [31:0] b,
  input  logic                      zero_in,
  input  logic                      halt_in,
  output irec_pkg::ex_res_t         res_o
);
  import irec_pkg::*;

  ex_res_t     r;
  logic [31:0] immw;
  logic [31:0] base;
  logic [32:0] sum;
  logic        addr_ok;
  logic        has;
  logic [31:0] val;

  always_comb begin
    r        = '0;
    immw     = {{16{imm[15]}}, imm};
    base     = (op == OP_STORE) ? b : a;
    // word address is signed base plus offset, checked before truncation
    sum      = {base[31], base} + {{17{imm[15]}}, imm};
    addr_ok  = !sum[32] && (sum[31:0] < 32'(MEM_WORDS));
    has      = 1'b0;
    val      = '0;
    r.next_pc  = pc + 16'd4;
    r.zero     = zero_in;
    r.halt     = halt_in;
    r.mem_addr = sum[MEM_AW-1:0];
    if (halt_in) begin
      r.next_pc = pc;
    end else begin
      case (op)
        OP_NOP: begin
        end
        OP_ADD: begin
          val    = a + b;
          has    = 1'b1;
          r.zero = (val == '0);
        end
        OP_SUB: begin
          val    = a - b;
          has    = 1'b1;
          r.zero = (val == '0);
        end
        OP_MUL: begin
          val    = a * b;
          has    = 1'b1;
          r.zero = (val == '0);
        end
        OP_AND: begin
          val = a & b;
          has = 1'b1;
        end
        OP_OR: begin
          val = a | b;
          has = 1'b1;
        end
        OP_XOR: begin
          val = a ^ b;
          has = 1'b1;
        end
        OP_MOVC: begin
          val = immw;
          has = 1'b1;
        end
        OP_LOAD: begin
          if (addr_ok) begin
            r.is_load = 1'b1;
            has       = 1'b1;
          end else begin
            r.addr_err = 1'b1;
          end
        end
        OP_STORE: begin
          if (addr_ok) begin
            r.is_store = 1'b1;
          end else begin
            r.addr_err = 1'b1;
          end
        end
        OP_BZ: begin
          if (zero_in) begin
            r.next_pc  = pc + immw[15:0];
            r.redirect = 1'b1;
          end
        end
        OP_BNZ: begin
          if (!zero_in) begin
            r.next_pc  = pc + immw[15:0];
            r.redirect = 1'b1;
          end
        end
        OP_JUMP: begin
          r.next_pc  = a[15:0] + immw[15:0];
          r.redirect = 1'b1;
        end
        OP_HALT: begin
          r.halt = 1'b1;
        end
        default: begin
        end
      endcase
      if (has && (32'(dest) < 32'(REG_COUNT))) begin
        r.wr   = 1'b1;
        r.widx = dest;
        r.res  = val;
      end
    end
  end

  assign res_o = r;

endmodule

// ----- design/in_order_risc_execute_core.sv -----
`timescale 1ns / 1ps

// Executes one decoded instruction per cycle unless stalled, with no load-use or branch
// bubbles: an instruction reads the register file as it is accepted, executes in the
// execute stage (where zero flag and halt mark are kept), accesses data memory as it
// enters the memory stage and shows its result in the output register; the register
// write happens as the result enters the output register. Operands are forwarded from the
// memory stage (including load data) and from the last register write. The single-port
// data memory sets the pace at one access per cycle. After reset the data memory is swept
// to zero, during which in_stall is held high. out_stall holds the output register and,
// once the two internal stages are full, stalls the input.
module in_order_risc_execute_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic        [3:0]  in_op,
  input  logic        [4:0]  in_dest_reg,
  input  logic        [4:0]  in_src_a,
  input  logic        [4:0]  in_src_b,
  input  logic signed [15:0] in_immediate,
  input  logic        [15:0] in_instr_pc,
  output logic               out_valid,
  input  logic               out_stall,
  output logic        [15:0] out_next_pc,
  output logic               out_redirect,
  output logic               out_reg_write,
  output logic        [4:0]  out_write_index,
  output logic signed [31:0] out_write_value,
  output logic               out_zero_now,
  output logic               out_halted_now,
  output logic               out_addr_error
);
  import irec_pkg::*;

  logic out_ready;
  logic mem_adv;
  logic ex_adv;
  logic ex_go;
  logic in_acc;
  logic dm_busy;

  // execute stage
  logic               ex_valid_r;
  logic        [3:0]  ex_op_r;
  logic        [4:0]  ex_dest_r;
  logic        [4:0]  ex_src_a_r;
  logic        [4:0]  ex_src_b_r;
  logic signed [15:0] ex_imm_r;
  logic        [15:0] ex_pc_r;
  logic               zero_r;
  logic               halt_r;

  // memory stage
  logic        mem_valid_r;
  logic [15:0] mem_next_pc_r;
  logic        mem_redirect_r;
  logic        mem_wr_r;
  logic [4:0]  mem_widx_r;
  logic [31:0] mem_alu_r;
  logic        mem_is_load_r;
  logic        mem_zero_r;
  logic        mem_halt_r;
  logic        mem_aerr_r;
  logic [31:0] mem_val;

  // last register write, covers the read that raced it
  logic        lw_valid_r;
  logic [4:0]  lw_idx_r;
  logic [31:0] lw_val_r;

  // output register
  logic        out_valid_r;
  logic [15:0] out_next_pc_r;
  logic        out_redirect_r;
  logic        out_reg_write_r;
  logic [4:0]  out_write_index_r;
  logic [31:0] out_write_value_r;
  logic        out_zero_now_r;
  logic        out_halted_now_r;
  logic        out_addr_error_r;

  logic [4:0]  rd_idx_a;
  logic [4:0]  rd_idx_b;
  logic [31:0] rf_a;
  logic [31:0] rf_b;
  logic [31:0] op_a;
  logic [31:0] op_b;
  rf_wr_t      rf_wr;
  dm_req_t     dm_req;
  logic [31:0] dm_rdata;
  ex_res_t     ex_res;

  assign out_ready = !out_valid_r || !out_stall;
  assign mem_adv   = !mem_valid_r || out_ready;
  assign ex_adv    = !ex_valid_r || mem_adv;
  assign ex_go     = ex_valid_r && mem_adv;
  assign in_stall  = dm_busy || !ex_adv;
  assign in_acc    = in_valid && !in_stall;

  // a held instruction re-reads its sources every cycle
  assign rd_idx_a = ex_adv ? in_src_a : ex_src_a_r;
  assign rd_idx_b = ex_adv ? in_src_b : ex_src_b_r;

  irec_regfile u_regfile (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_idx_a  (rd_idx_a),
    .rd_idx_b  (rd_idx_b),
    .wr        (rf_wr),
    .rd_data_a (rf_a),
    .rd_data_b (rf_b)
  );

  assign mem_val = mem_is_load_r ? dm_rdata : mem_alu_r;

  always_comb begin
    if (mem_valid_r && mem_wr_r && (mem_widx_r == ex_src_a_r)) begin
      op_a = mem_val;
    end else if (lw_valid_r && (lw_idx_r == ex_src_a_r)) begin
      op_a = lw_val_r;
    end else begin
      op_a = rf_a;
    end
    if (mem_valid_r && mem_wr_r && (mem_widx_r == ex_src_b_r)) begin
      op_b = mem_val;
    end else if (lw_valid_r && (lw_idx_r == ex_src_b_r)) begin
      op_b = lw_val_r;
    end else begin
      op_b = rf_b;
    end
  end

  irec_alu u_alu (
    .op      (ex_op_r),
    .dest    (ex_dest_r),
    .imm     (ex_imm_r),
    .pc      (ex_pc_r),
    .a       (op_a),
    .b       (op_b),
    .zero_in (zero_r),
    .halt_in (halt_r),
    .res_o   (ex_res)
  );

  always_comb begin
    dm_req       = '0;
    dm_req.wr_en = ex_go && ex_res.is_store;
    dm_req.rd_en = ex_go && ex_res.is_load;
    dm_req.addr  = ex_res.mem_addr;
    dm_req.wdata = op_a;
  end

  irec_dmem u_dmem (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (dm_req),
    .rd_data (dm_rdata),
    .busy    (dm_busy)
  );

  always_comb begin
    rf_wr      = '0;
    rf_wr.en   = mem_valid_r && out_ready && mem_wr_r;
    rf_wr.idx  = mem_widx_r;
    rf_wr.data = mem_val;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ex_valid_r  <= 1'b0;
      mem_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      zero_r      <= 1'b0;
      halt_r      <= 1'b0;
      lw_valid_r  <= 1'b0;
    end else begin
      if (ex_adv) begin
        ex_valid_r <= in_acc;
      end
      if (mem_adv) begin
        mem_valid_r <= ex_valid_r;
      end
      if (out_ready) begin
        out_valid_r <= mem_valid_r;
      end
      if (ex_go) begin
        zero_r <= ex_res.zero;
        halt_r <= ex_res.halt;
      end
      if (rf_wr.en) begin
        lw_valid_r <= 1'b1;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      ex_op_r    <= in_op;
      ex_dest_r  <= in_dest_reg;
      ex_src_a_r <= in_src_a;
      ex_src_b_r <= in_src_b;
      ex_imm_r   <= in_immediate;
      ex_pc_r    <= in_instr_pc;
    end
    if (ex_go) begin
      mem_next_pc_r  <= ex_res.next_pc;
      mem_redirect_r <= ex_res.redirect;
      mem_wr_r       <= ex_res.wr;
      mem_widx_r     <= ex_res.widx;
      mem_alu_r      <= ex_res.res;
      mem_is_load_r  <= ex_res.is_load;
      mem_zero_r     <= ex_res.zero;
      mem_halt_r     <= ex_res.halt;
      mem_aerr_r     <= ex_res.addr_err;
    end
    if (rf_wr.en) begin
      lw_idx_r <= rf_wr.idx;
      lw_val_r <= rf_wr.data;
    end
    if (mem_valid_r && out_ready) begin
      out_next_pc_r     <= mem_next_pc_r;
      out_redirect_r    <= mem_redirect_r;
      out_reg_write_r   <= mem_wr_r;
      out_write_index_r <= mem_widx_r;
      out_write_value_r <= mem_wr_r ? mem_val : '0;
      out_zero_now_r    <= mem_zero_r;
      out_halted_now_r  <= mem_halt_r;
      out_addr_error_r  <= mem_aerr_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_next_pc     = out_next_pc_r;
  assign out_redirect    = out_redirect_r;
  assign out_reg_write   = out_reg_write_r;
  assign out_write_index = out_write_index_r;
  assign out_write_value = out_write_value_r;
  assign out_zero_now    = out_zero_now_r;
  assign out_halted_now  = out_halted_now_r;
  assign out_addr_error  = out_addr_error_r;

  a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    dm_busy |-> in_stall)
    else $error("transaction accepted during memory clear");

  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halt_r |=> halt_r)
    else $error("halt mark dropped");

  a_halted_no_mem_access: assert property (@(posedge clk) disable iff (!rst_n)
    (ex_valid_r && halt_r) |-> (!dm_req.wr_en && !dm_req.rd_en))
    else $error("memory access after halt");

  a_addr_error_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_addr_error_r) |-> !out_reg_write_r)
    else $error("register written by faulting access");

endmodule
